// ===== rtl/ins_sort_pkg.sv =====
// Shared types and constants for the insertion sorter.
package ins_sort_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PUT0,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        WR_SRC_IN,
        WR_SRC_VALUE,
        WR_SRC_RDATA
    } t_wr_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    wr_en;
        t_wr_src wr_src;
        logic    wr_at_zero;
        logic    rd_start;
        logic    rd_down;
        logic    emit_start;
        logic    emit_next;
        logic    out_load;
        logic    cnt_inc;
        logic    list_clear;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic in_last;
        logic held_last;
        logic less;
        logic ptr_zero;
        logic idx_last;
    } t_dp_status;

endpackage

// ===== rtl/ins_sort_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ins_sort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ins_sort_dp.sv =====
// Datapath of the insertion sorter: store, pointers, count and output register.
module ins_sort_dp
    import ins_sort_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    output t_dp_status         o_status,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_final,
    output logic               o_overflow
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic               r_drop;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_idx;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_final;
    logic               r_out_ovf;

    logic [CW-1:0]      w_cnt_m1;
    logic [CW-1:0]      w_idx_p1;
    logic [AW-1:0]      w_wr_addr;
    logic [VALUE_W-1:0] w_wr_data;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [VALUE_W-1:0] w_rd_data;
    logic               w_full;
    logic               w_idx_last;

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_idx_p1   = CW'(r_idx) + CW'(1);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_idx_last = (w_idx_p1 == r_count);

    assign w_wr_addr = i_cmd.wr_at_zero ? '0 : (r_ptr + AW'(1));

    always_comb begin
        case (i_cmd.wr_src)
            WR_SRC_IN:    w_wr_data = i_value;
            WR_SRC_VALUE: w_wr_data = r_value;
            WR_SRC_RDATA: w_wr_data = w_rd_data;
            default:      w_wr_data = r_value;
        endcase
    end

    assign w_rd_en = i_cmd.rd_start | i_cmd.rd_down | i_cmd.emit_start | i_cmd.emit_next;

    always_comb begin
        if (i_cmd.rd_start) begin
            w_rd_addr = w_cnt_m1[AW-1:0];
        end else if (i_cmd.rd_down) begin
            w_rd_addr = r_ptr - AW'(1);
        end else if (i_cmd.emit_next) begin
            w_rd_addr = r_idx + AW'(1);
        end else begin
            w_rd_addr = '0;
        end
    end

    ins_sort_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.list_clear) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.accept && w_full) begin
                r_drop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_value;
            r_last  <= i_last;
        end
        if (i_cmd.rd_start) begin
            r_ptr <= w_cnt_m1[AW-1:0];
        end else if (i_cmd.rd_down) begin
            r_ptr <= r_ptr - AW'(1);
        end
        if (i_cmd.emit_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit_next) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_out_value <= w_rd_data;
            r_out_final <= w_idx_last;
            r_out_ovf   <= r_drop;
        end
    end

    assign o_status.full      = w_full;
    assign o_status.empty     = (r_count == '0);
    assign o_status.in_last   = i_last;
    assign o_status.held_last = r_last;
    assign o_status.less      = ($signed(r_value) < $signed(w_rd_data));
    assign o_status.ptr_zero  = (r_ptr == '0);
    assign o_status.idx_last  = w_idx_last;

    assign o_value    = r_out_value;
    assign o_final    = r_out_final;
    assign o_overflow = r_out_ovf;

endmodule

// ===== rtl/ins_sort_ctrl.sv =====
// Controller of the insertion sorter: sequences insertion and sorted read-out.
module ins_sort_ctrl
    import ins_sort_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT_WAIT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.full) begin
                        n_state = i_status.in_last ? S_EMIT_RD : S_IDLE;
                    end else if (i_status.empty) begin
                        o_cmd.wr_en      = 1'b1;
                        o_cmd.wr_src     = WR_SRC_IN;
                        o_cmd.wr_at_zero = 1'b1;
                        o_cmd.cnt_inc    = 1'b1;
                        n_state = i_status.in_last ? S_EMIT_RD : S_IDLE;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_status.less) begin
                    // Move the larger entry up one place and look one lower.
                    o_cmd.wr_src = WR_SRC_RDATA;
                    if (i_status.ptr_zero) begin
                        n_state = S_PUT0;
                    end else begin
                        o_cmd.rd_down = 1'b1;
                    end
                end else begin
                    o_cmd.wr_src  = WR_SRC_VALUE;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = i_status.held_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PUT0: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_src     = WR_SRC_VALUE;
                o_cmd.wr_at_zero = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                n_state = i_status.held_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                o_cmd.emit_start = 1'b1;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    if (i_status.idx_last) begin
                        o_cmd.list_clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_EMIT_LD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/insertion_sorter_unit.sv =====
// Top level of the streaming insertion sorter for signed 32-bit lists.
// Usage: list elements arrive on the s_axis channel, one per transfer, with
// s_axis_tlast marking the final element of a list. Each element is placed
// into a sorted store of CAPACITY entries; larger entries move up one place
// and equal values keep their arrival order. After the last element is
// inserted, the whole list leaves on m_axis in ascending order, with
// m_axis_tlast on the final result and m_axis_tuser set on every result of a
// list that lost elements because the store was full. The store then empties.
// Timing: an element that lands in an empty or full store is written or
// dropped as it is taken. Otherwise insertion reads the top entry, then S_CMP
// moves one larger entry up per cycle through the single read and single
// write port of the store, then writes the element, in S_PUT0 at the bottom.
// After the last element is inserted, S_EMIT_RD reads the first entry and
// S_EMIT_LD loads the result register, as it does again after each transfer.
// Input is not taken while an element is being inserted or a list emitted.
// A stall on m_axis holds the result steady. A synchronous reset empties
// the store at once; contents need no clearing, only filled entries are read.
module insertion_sorter_unit
    import ins_sort_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic        s_axis_tlast,  // end_of_list
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] sorted_value
    output logic        m_axis_tlast,  // final_element
    output logic        m_axis_tuser   // [0] overflowed
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // The controller owns the handshakes; the datapath owns all storage.
    ins_sort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_status   (st),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_cmd      (cmd)
    );

    ins_sort_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_value   (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_status  (st),
        .o_value   (m_axis_tdata),
        .o_final   (m_axis_tlast),
        .o_overflow(m_axis_tuser)
    );

`ifndef SYNTHESIS
    // Input and output phases never overlap.
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // A result can only be offered while the store holds entries.
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !st.empty)
        else $error("result offered from an empty store");

    // After the final result of a list is taken, the store is empty and idle.
    a_end_of_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            |=> (!m_axis_tvalid && st.empty && s_axis_tready))
        else $error("store not emptied after the final result");
`endif

endmodule
